>>> rtl/rpn_stack_evaluator_defines.svh
// assertion macros shared by the evaluator rtl
`ifndef RPN_STACK_EVALUATOR_DEFINES_SVH
`define RPN_STACK_EVALUATOR_DEFINES_SVH

// cons must hold in the same cycle as ante, checked on clk, off while arst_n is low
`define RPN_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rpn assertion failed");

// cons must hold in the cycle after ante
`define RPN_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rpn assertion failed");

`endif

>>> rtl/rpn_pkg.sv
// types and constants of the rpn stack evaluator
`timescale 1ns / 1ps

package rpn_pkg;

	localparam int DATA_W   = 32;
	localparam int MODE_W   = 3;
	localparam int STATUS_W = 2;

	// token kinds
	localparam logic [MODE_W-1:0] MODE_PUSH = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ADD  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SUB  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_MUL  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DIV  = 3'd4;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_UNDER = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_OVER  = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_DIVZ  = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_EMIT
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load_tok;
		logic commit;
		logic use_quot;
		logic div_start;
		logic emit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_div;
		logic div_done;
		logic last;
		logic res_free;
	} dp_stat_t;

endpackage

>>> rtl/rpn_if.sv
// token and result channel interfaces
`timescale 1ns / 1ps

interface rpn_token_if;
	logic                              valid;
	logic                              ready;
	logic [rpn_pkg::MODE_W-1:0]        mode;
	logic signed [rpn_pkg::DATA_W-1:0] operand_value;
	logic                              last_token;

	modport source (output valid, output mode, output operand_value, output last_token,
		input ready);
	modport sink (input valid, input mode, input operand_value, input last_token,
		output ready);
endinterface

interface rpn_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [rpn_pkg::DATA_W-1:0]  final_value;
	logic [rpn_pkg::STATUS_W-1:0]       status;

	modport source (output valid, output final_value, output status, input ready);
	modport sink (input valid, input final_value, input status, output ready);
endinterface

>>> rtl/rpn_div.sv
// radix-2 restoring signed divider, truncating toward zero, one quotient bit per cycle
`timescale 1ns / 1ps
`include "rpn_stack_evaluator_defines.svh"

module rpn_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rpn_pkg::DATA_W-1:0] dividend,
	input  logic [rpn_pkg::DATA_W-1:0] divisor,
	output logic                       busy,
	output logic                       done,
	output logic [rpn_pkg::DATA_W-1:0] quotient
);
	import rpn_pkg::*;

	localparam int CNT_W = $clog2(DATA_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dvs_q;

	logic [DATA_W-1:0] mag_a;
	logic [DATA_W-1:0] mag_b;
	logic [DATA_W:0]   rem_sh;
	logic [DATA_W:0]   rem_sub;
	logic              take;

	// operand magnitudes; the most negative value maps to itself as unsigned
	assign mag_a = dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
	assign mag_b = divisor[DATA_W-1] ? (~divisor + DATA_W'(1)) : divisor;

	// one restoring step, the remainder stays below the divisor
	assign rem_sh  = {rem_q, quo_q[DATA_W-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign take    = !rem_sub[DATA_W];

	// control: bit counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= mag_a;
			dvs_q <= mag_b;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (busy_q) begin
			rem_q <= take ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], take};
		end
	end

	// sign fix on the way out
	assign quotient = neg_q ? (~quo_q + DATA_W'(1)) : quo_q;
	assign busy     = busy_q;
	assign done     = done_q;

	`RPN_ASSERT_IMP(a_no_restart, start, !busy_q)
	`RPN_ASSERT_NXT(a_done_ends_busy, done_q, !done_q && !busy_q)
	`RPN_ASSERT_IMP(a_done_not_busy, done_q, !busy_q)
endmodule

>>> rtl/rpn_dpath.sv
// datapath: operand stack memory, stack pointer, error code, alu, divider, result register
`timescale 1ns / 1ps
`include "rpn_stack_evaluator_defines.svh"

module rpn_dpath #(
	parameter int STACK_DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rpn_pkg::dp_cmd_t             cmd,
	output rpn_pkg::dp_stat_t            stat,
	input  logic [rpn_pkg::MODE_W-1:0]   tok_mode,
	input  logic [rpn_pkg::DATA_W-1:0]   tok_value,
	input  logic                         tok_last,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [rpn_pkg::DATA_W-1:0]   res_value,
	output logic [rpn_pkg::STATUS_W-1:0] res_status
);
	import rpn_pkg::*;

	localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SP_W = $clog2(STACK_DEPTH + 1);
	localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);

	// stack memory, entries above the pointer may be read but their values are never used
	logic [DATA_W-1:0] stack_mem [STACK_DEPTH];

	logic [SP_W-1:0]     sp_q;
	logic [STATUS_W-1:0] err_q;
	logic [MODE_W-1:0]   mode_q;
	logic [DATA_W-1:0]   value_q;
	logic                last_q;
	logic [DATA_W-1:0]   rd_top_q;
	logic [DATA_W-1:0]   rd_nxt_q;
	logic [DATA_W-1:0]   fin_val_q;
	logic [STATUS_W-1:0] fin_st_q;
	logic                out_valid_q;
	logic [DATA_W-1:0]   out_val_q;
	logic [STATUS_W-1:0] out_st_q;

	logic [SP_W-1:0]     sp_m1;
	logic [SP_W-1:0]     sp_m2;
	logic [AW-1:0]       top_addr;
	logic [AW-1:0]       nxt_addr;
	logic                is_arith;
	logic                two_held;
	logic                no_err;
	logic [DATA_W-1:0]   alu_res;
	logic [DATA_W-1:0]   prod;
	logic [DATA_W-1:0]   quot;
	logic                div_busy;
	logic                div_done;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [DATA_W-1:0]   wr_data;
	logic [SP_W-1:0]     sp_new;
	logic [STATUS_W-1:0] err_new;
	logic [DATA_W-1:0]   top_new;
	logic [STATUS_W-1:0] fin_st;
	logic [DATA_W-1:0]   fin_val;
	logic                res_free;

	assign sp_m1    = sp_q - SP_W'(1);
	assign sp_m2    = sp_q - SP_W'(2);
	assign top_addr = sp_m1[AW-1:0];
	assign nxt_addr = sp_m2[AW-1:0];
	assign no_err   = (err_q == STAT_OK);
	assign two_held = (sp_q >= SP_W'(2));
	assign is_arith = (mode_q == MODE_ADD) || (mode_q == MODE_SUB) ||
		(mode_q == MODE_MUL) || (mode_q == MODE_DIV);

	// token capture and stack reads
	always_ff @(posedge clk) begin
		if (cmd.load_tok) begin
			mode_q   <= tok_mode;
			value_q  <= tok_value;
			last_q   <= tok_last;
			rd_top_q <= stack_mem[top_addr];
			rd_nxt_q <= stack_mem[nxt_addr];
		end
		if (wr_en) begin
			stack_mem[wr_addr] <= wr_data;
		end
	end

	// divider, left operand over right
	rpn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (rd_nxt_q),
		.divisor  (rd_top_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quot)
	);

	// alu result, low word of the product wraps like the other ops
	assign prod = rd_nxt_q * rd_top_q;

	always_comb begin
		unique case (mode_q)
			MODE_ADD: alu_res = rd_nxt_q + rd_top_q;
			MODE_SUB: alu_res = rd_nxt_q - rd_top_q;
			MODE_MUL: alu_res = prod;
			default:  alu_res = quot;
		endcase
		if (cmd.use_quot) begin
			alu_res = quot;
		end
	end

	// token effect on stack, pointer and error
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = sp_q[AW-1:0];
		wr_data = value_q;
		sp_new  = sp_q;
		err_new = err_q;
		if (no_err) begin
			if (mode_q == MODE_PUSH) begin
				if (sp_q == SP_FULL) begin
					err_new = STAT_OVER;
				end else begin
					wr_en  = 1'b1;
					sp_new = sp_q + SP_W'(1);
				end
			end else if (is_arith) begin
				if (!two_held) begin
					err_new = STAT_UNDER;
				end else if ((mode_q == MODE_DIV) && (rd_top_q == '0)) begin
					err_new = STAT_DIVZ;
				end else begin
					wr_en   = 1'b1;
					wr_addr = nxt_addr;
					wr_data = alu_res;
					sp_new  = sp_m1;
				end
			end
		end
		wr_en = wr_en && cmd.commit;
	end

	// final value and status if this is the last token
	always_comb begin
		top_new = wr_en ? wr_data : rd_top_q;
		fin_st  = err_new;
		if ((err_new == STAT_OK) && (sp_new == '0)) begin
			fin_st = STAT_UNDER;
		end
		fin_val = (fin_st == STAT_OK) ? top_new : '0;
	end

	// pointer and error state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q  <= '0;
			err_q <= STAT_OK;
		end else if (cmd.commit) begin
			if (last_q) begin
				sp_q  <= '0;
				err_q <= STAT_OK;
			end else begin
				sp_q  <= sp_new;
				err_q <= err_new;
			end
		end
	end

	// held final result
	always_ff @(posedge clk) begin
		if (cmd.commit && last_q) begin
			fin_val_q <= fin_val;
			fin_st_q  <= fin_st;
		end
	end

	// output register
	assign res_free = !out_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_val_q <= fin_val_q;
			out_st_q  <= fin_st_q;
		end
	end

	assign res_valid  = out_valid_q;
	assign res_value  = out_val_q;
	assign res_status = out_st_q;

	// status to the controller
	assign stat.need_div = no_err && (mode_q == MODE_DIV) && two_held && (rd_top_q != '0);
	assign stat.div_done = div_done;
	assign stat.last     = last_q;
	assign stat.res_free = res_free;

	`RPN_ASSERT_IMP(a_sp_bound, 1'b1, sp_q <= SP_FULL)
	`RPN_ASSERT_NXT(a_last_clears, cmd.commit && last_q, (sp_q == '0) && (err_q == STAT_OK))
	`RPN_ASSERT_IMP(a_err_zero_val, out_valid_q && (out_st_q != STAT_OK), out_val_q == '0)
	`RPN_ASSERT_IMP(a_emit_free, cmd.emit, res_free)
	`RPN_ASSERT_IMP(a_div_idle_start, cmd.div_start, !div_busy)
endmodule

>>> rtl/rpn_ctrl.sv
// controller state machine: token accept, execute, divide wait, result emit
`timescale 1ns / 1ps

module rpn_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tok_valid,
	output logic               tok_ready,
	input  rpn_pkg::dp_stat_t  stat,
	output rpn_pkg::dp_cmd_t   cmd
);
	import rpn_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (tok_valid) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				priority if (stat.need_div) state_nxt = S_DIV;
				else if (stat.last)         state_nxt = S_EMIT;
				else                        state_nxt = S_IDLE;
			end
			S_DIV: begin
				if (stat.div_done) begin
					state_nxt = stat.last ? S_EMIT : S_IDLE;
				end
			end
			S_EMIT: begin
				if (stat.res_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		tok_ready = 1'b0;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				tok_ready    = 1'b1;
				cmd.load_tok = tok_valid;
			end
			S_EXEC: begin
				cmd.commit    = !stat.need_div;
				cmd.div_start = stat.need_div;
			end
			S_DIV: begin
				cmd.commit   = stat.div_done;
				cmd.use_quot = 1'b1;
			end
			S_EMIT: begin
				cmd.emit = stat.res_free;
			end
			default: begin
				tok_ready = 1'b0;
			end
		endcase
	end
endmodule

>>> rtl/rpn_stack_evaluator.sv
// top level of the rpn stack evaluator
`timescale 1ns / 1ps

// Evaluates an integer expression in reverse Polish notation, one token per request on
// the token channel. An operand token pushes a signed 32-bit value; an operator pops the
// right then the left operand and pushes their sum, difference, product or quotient
// (32-bit wrap, division truncates toward zero). On the token marked last one request
// leaves on the result channel with the top of stack and a status (0 ok, 1 underflow,
// 2 overflow, 3 division by zero, value 0 on error), and the stack is emptied; after the
// first error the rest of the expression is ignored. Push, add, subtract, multiply and
// ignored tokens pass an accept and an execute step against two registered stack reads;
// a divide adds a wait for the radix-2 divider, which produces one quotient bit per
// cycle; a last token adds an emit step to load the result register. The next token is
// taken while an earlier result still waits in the output register. The stack is a
// STACK_DEPTH x 32 memory with one write and two read ports; it needs no clearing pass.
module rpn_stack_evaluator #(
	parameter int STACK_DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	rpn_token_if.sink     token,
	rpn_result_if.source  result
);
	import rpn_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// controller
	rpn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (token.valid),
		.tok_ready (token.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath
	rpn_dpath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.tok_mode   (token.mode),
		.tok_value  (token.operand_value),
		.tok_last   (token.last_token),
		.res_valid  (result.valid),
		.res_ready  (result.ready),
		.res_value  (result.final_value),
		.res_status (result.status)
	);
endmodule
